// ----- rtl/jhtb_pkg.sv -----
// Shared types, codes and helpers for the JPEG Huffman table builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jhtb_pkg;

  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int NUM_LENGTHS_DEF = 16;

  localparam logic [1:0] KIND_ROW     = 2'd0;
  localparam logic [1:0] KIND_CODE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MANY  = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;
  localparam logic [1:0] STAT_AFTER = 2'd3;

  localparam logic [15:0] CODE_SAT = 16'hFFFF;
  localparam logic [16:0] RUN_SAT  = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         code_length;
    logic [15:0]        min_code;
    logic signed [16:0] max_code;
    logic [7:0]         first_index;
    logic [7:0]         symbol;
    logic [15:0]        code;
    logic [1:0]         status;
    logic               last;
  } jhtb_result_t;

  // count byte write into the length table
  typedef struct packed {
    logic        en;
    logic [4:0]  pos;
    logic [7:0]  count;
    logic [15:0] min_code;
  } jhtb_wr_t;

  // next non-empty length above the current one
  typedef struct packed {
    logic        hit;
    logic [4:0]  length;
    logic [7:0]  count;
    logic [15:0] min_code;
  } jhtb_look_t;

  function automatic logic [15:0] sat16(input logic [18:0] v);
    return (v > 19'(CODE_SAT)) ? CODE_SAT : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/jpeg_huffman_table_builder_top.sv -----
// JPEG canonical Huffman table builder: input register, parse core, result register.
// Each request passes the input register, then the result register, before m_tvalid.
// Throughput: one byte per cycle unless m_tvalid stalls; the parse loop is unpipelined.
// Reset (rst, synchronous): parse waits for a new table, both register stages empty.
// Depends on jhtb_pkg and jhtb_core.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_huffman_table_builder_top
  import jhtb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // byte_value
  input  wire logic        s_tuser,  // first
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // code_length, min_code, max_code, first_index,
                                     // symbol, code, status
  output logic [1:0]       m_tuser,  // kind
  output logic             m_tlast   // last
);

  logic         in_valid;
  logic         in_first;
  logic [7:0]   in_byte;
  logic         advance;
  jhtb_result_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_first <= s_tuser;
      in_byte  <= s_tdata;
    end
  end

  jhtb_core #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .NUM_LENGTHS(NUM_LENGTHS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .first(in_first),
    .byte_value(in_byte),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.status, res.code, res.symbol, res.first_index, res.max_code,
                  res.min_code, res.code_length};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jhtb_len_table.sv -----
// Per-length count and minimum-code table with next non-empty length search.
// Depends on jhtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jhtb_len_table
  import jhtb_pkg::*;
#(
  parameter int NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire jhtb_wr_t   wr,
  input  wire logic [4:0] cur_len,
  output jhtb_look_t      look
);

  localparam int IDX_W = (NUM_LENGTHS > 1) ? $clog2(NUM_LENGTHS) : 1;

  logic [7:0]             counts [NUM_LENGTHS];
  logic [15:0]            mins   [NUM_LENGTHS];
  logic [NUM_LENGTHS-1:0] nz;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      counts[wr.pos[IDX_W-1:0]] <= wr.count;
      mins[wr.pos[IDX_W-1:0]]   <= wr.min_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz <= '0;
    end else if (wr.en) begin
      nz[wr.pos[IDX_W-1:0]] <= (wr.count != 8'd0);
    end
  end

  always_comb begin
    logic             hit;
    logic [IDX_W-1:0] sel;
    hit = 1'b0;
    sel = '0;
    for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
      if (nz[i] && (5'(i) >= cur_len)) begin
        hit = 1'b1;
        sel = IDX_W'(i);
      end
    end
    look.hit      = hit;
    look.length   = 5'(sel) + 5'd1;
    look.count    = counts[sel];
    look.min_code = mins[sel];
  end

endmodule
`default_nettype wire

// ----- rtl/jhtb_core.sv -----
// Parse state and per-byte result logic: decoder rows, symbol codes, then ignored bytes.
// Depends on jhtb_pkg and jhtb_len_table.
`timescale 1ns / 1ps
`default_nettype none
module jhtb_core
  import jhtb_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       first,
  input  wire logic [7:0] byte_value,
  output jhtb_result_t    res
);

  logic [4:0]  count_position, count_position_next;
  logic [16:0] running_code, running_code_next;
  logic [11:0] total_symbols, total_symbols_next;
  logic [8:0]  symbol_index, symbol_index_next;
  logic [4:0]  current_length, current_length_next;
  logic [7:0]  remaining, remaining_next;
  logic [15:0] next_code, next_code_next;
  logic [1:0]  error_seen, error_seen_next;

  jhtb_wr_t   wr;
  jhtb_look_t look;

  // effective state, after a restart on the first byte
  logic [4:0]  e_pos;
  logic [16:0] e_run;
  logic [11:0] e_total;
  logic [8:0]  e_sidx;
  logic [4:0]  e_clen;
  logic [7:0]  e_rem;
  logic [15:0] e_next;
  logic [1:0]  e_err;

  assign e_pos   = first ? '0 : count_position;
  assign e_run   = first ? '0 : running_code;
  assign e_total = first ? '0 : total_symbols;
  assign e_sidx  = first ? '0 : symbol_index;
  assign e_clen  = first ? '0 : current_length;
  assign e_rem   = first ? '0 : remaining;
  assign e_next  = first ? '0 : next_code;
  assign e_err   = first ? STAT_OK : error_seen;

  jhtb_len_table #(
    .NUM_LENGTHS(NUM_LENGTHS)
  ) u_len_table (
    .clk(clk),
    .rst(rst),
    .wr(wr),
    .cur_len(e_clen),
    .look(look)
  );

  always_comb begin
    logic [17:0] sum;
    logic [17:0] limit;
    logic [18:0] dbl;
    logic [11:0] tsum;
    logic [8:0]  expected;
    logic [4:0]  clen;
    logic [7:0]  rem;
    logic [15:0] nc;
    logic [1:0]  err;

    sum      = {1'b0, e_run} + 18'(byte_value);
    limit    = 18'd1 << (e_pos + 5'd1);
    dbl      = {sum, 1'b0};
    tsum     = e_total + 12'(byte_value);
    expected = (e_total > 12'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS) : e_total[8:0];
    clen     = e_clen;
    rem      = e_rem;
    nc       = e_next;
    err      = e_err;

    res                 = '0;
    wr                  = '0;
    count_position_next = e_pos;
    running_code_next   = e_run;
    total_symbols_next  = e_total;
    symbol_index_next   = e_sidx;
    current_length_next = e_clen;
    remaining_next      = e_rem;
    next_code_next      = e_next;
    error_seen_next     = e_err;

    priority if (e_pos < 5'(NUM_LENGTHS)) begin
      if (sum > limit && err == STAT_OK) err = STAT_OVF;
      if (tsum > 12'(MAX_SYMBOLS) && err == STAT_OK) err = STAT_MANY;
      res.kind        = KIND_ROW;
      res.code_length = e_pos + 5'd1;
      if (byte_value == 8'd0) begin
        res.max_code = 17'h1FFFF;
      end else begin
        res.min_code    = sat16(19'(e_run));
        res.max_code    = 17'(sat16(19'(sum - 18'd1)));
        res.first_index = e_total[7:0];
      end
      wr.en       = step;
      wr.pos      = e_pos;
      wr.count    = byte_value;
      wr.min_code = sat16(19'(e_run));
      running_code_next   = (dbl > 19'(RUN_SAT)) ? RUN_SAT : dbl[16:0];
      total_symbols_next  = tsum;
      count_position_next = e_pos + 5'd1;
      error_seen_next     = err;
      res.last   = (e_pos + 5'd1 >= 5'(NUM_LENGTHS)) && (tsum == 12'd0);
      res.status = err;
    end else if (e_sidx < expected) begin
      if (e_rem == 8'd0) begin
        if (look.hit) begin
          clen = look.length;
          rem  = look.count;
          nc   = look.min_code;
        end else begin
          clen = '0;
          nc   = '0;
        end
      end
      res.kind            = KIND_CODE;
      res.code_length     = clen;
      res.symbol          = byte_value;
      res.code            = nc;
      current_length_next = clen;
      next_code_next      = (nc < CODE_SAT) ? nc + 16'd1 : nc;
      remaining_next      = (rem != 8'd0) ? rem - 8'd1 : rem;
      symbol_index_next   = e_sidx + 9'd1;
      res.last            = (e_sidx + 9'd1 >= expected);
      res.status          = e_err;
    end else begin
      res.kind   = KIND_IGNORED;
      res.status = STAT_AFTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_position <= '0;
      running_code   <= '0;
      total_symbols  <= '0;
      symbol_index   <= '0;
      current_length <= '0;
      remaining      <= '0;
      next_code      <= '0;
      error_seen     <= STAT_OK;
    end else if (step) begin
      count_position <= count_position_next;
      running_code   <= running_code_next;
      total_symbols  <= total_symbols_next;
      symbol_index   <= symbol_index_next;
      current_length <= current_length_next;
      remaining      <= remaining_next;
      next_code      <= next_code_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jhtb_checker.sv -----
// Port-level checks for the Huffman table builder, bound to the top level.
// Depends on jhtb_pkg and jpeg_huffman_table_builder_top.
`timescale 1ns / 1ps
`default_nettype none
module jhtb_checker
  import jhtb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_after: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_IGNORED) == (m_tdata[71:70] == STAT_AFTER)))
    else $error("ignored kind and byte-after-table status disagree");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_IGNORED |-> m_tdata[69:0] == '0 && !m_tlast)
    else $error("ignored byte carries data");

  a_row_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ROW |-> m_tdata[4:0] != 5'd0 && m_tdata[4:0] <= 5'd16)
    else $error("row length out of range");

  a_empty_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ROW && m_tdata[37:21] == 17'h1FFFF
      |-> m_tdata[20:5] == 16'd0 && m_tdata[45:38] == 8'd0)
    else $error("empty row has nonzero min code or index");

endmodule

bind jpeg_huffman_table_builder_top jhtb_checker u_jhtb_checker (.*);
`default_nettype wire

// ----- verif/tb_jpeg_huffman_table_builder_top.sv -----
// Self-checking bench for jpeg_huffman_table_builder_top: directed tables, then random tables.
// Predicts results in-bench or uses fixed ones; checks each against the stream output in order.
// Depends on jhtb_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_jpeg_huffman_table_builder_top;
  import jhtb_pkg::*;

  localparam int NLEN      = NUM_LENGTHS_DEF;
  localparam int MAXSYM    = MAX_SYMBOLS_DEF;
  localparam int N_RANDOM  = 1650;
  localparam int LIMIT     = 1000000;

  typedef enum int {SHAPE_PLAIN, SHAPE_OVF, SHAPE_BIG, SHAPE_NOISE} shape_t;

  typedef struct {
    logic         first;
    logic [7:0]   val;
    logic         typed;
    jhtb_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // typed expectation travels with the request
  logic         exp_typed = 1'b0;
  jhtb_result_t exp_fixed = '0;

  jhtb_result_t want_q[$];
  jhtb_result_t pred_res, got_res, want_res;
  dir_row_t     dir_rows[$];

  int errors = 0;
  int items = 0;
  int results_seen = 0;
  int cycles = 0;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  int rx_hold = 0;

  // predictor state
  int          cnt_pos;
  int          len_cnt[NLEN];
  int          len_min[NLEN];
  int          run_code;
  int          sym_total;
  int          sym_done;
  int          cur_len;
  int          left_in_len;
  int          code_next;
  logic [1:0]  err_code;

  jpeg_huffman_table_builder_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] clip16(input int v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void clear_table();
    cnt_pos = 0;
    for (int k = 0; k < NLEN; k++) begin
      len_cnt[k] = 0;
      len_min[k] = 0;
    end
    run_code = 0;
    sym_total = 0;
    sym_done = 0;
    cur_len = 0;
    left_in_len = 0;
    code_next = 0;
    err_code = STAT_OK;
  endfunction

  function automatic jhtb_result_t build_step(input logic first, input logic [7:0] b);
    jhtb_result_t r;
    int sum, dbl, lim, l;
    r = '0;
    if (first) clear_table();
    lim = (sym_total > MAXSYM) ? MAXSYM : sym_total;
    if (cnt_pos < NLEN) begin
      sum = run_code + b;
      if (sum > (1 << (cnt_pos + 1)) && err_code == STAT_OK) err_code = STAT_OVF;
      r.kind = KIND_ROW;
      r.code_length = 5'(cnt_pos + 1);
      if (b == 0) begin
        r.max_code = '1;
      end else begin
        r.min_code = clip16(run_code);
        r.max_code = {1'b0, clip16(sum - 1)};
        r.first_index = 8'(sym_total);
      end
      len_cnt[cnt_pos] = b;
      len_min[cnt_pos] = clip16(run_code);
      dbl = sum * 2;
      run_code = (dbl > 'h1FFFF) ? 'h1FFFF : dbl;
      sym_total = (sym_total + b) & 'hFFF;
      if (sym_total > MAXSYM && err_code == STAT_OK) err_code = STAT_MANY;
      cnt_pos++;
      if (cnt_pos >= NLEN && sym_total == 0) r.last = 1'b1;
      r.status = err_code;
    end else if (sym_done < lim) begin
      if (left_in_len == 0) begin
        l = cur_len;
        while (l < NLEN && len_cnt[l] == 0) l++;
        if (l < NLEN) begin
          cur_len = l + 1;
          left_in_len = len_cnt[l];
          code_next = len_min[l];
        end else begin
          cur_len = 0;
          code_next = 0;
        end
      end
      r.kind = KIND_CODE;
      r.code_length = 5'(cur_len);
      r.symbol = b;
      r.code = 16'(code_next);
      if (code_next < 65535) code_next++;
      if (left_in_len > 0) left_in_len--;
      sym_done++;
      if (sym_done >= lim) r.last = 1'b1;
      r.status = err_code;
    end else begin
      r.kind = KIND_IGNORED;
      r.status = STAT_AFTER;
    end
    return r;
  endfunction

  function automatic jhtb_result_t row_res(input int len, input logic [15:0] minc,
                                           input logic [16:0] maxc, input logic [1:0] st,
                                           input logic lst);
    jhtb_result_t r;
    r = '0;
    r.kind = KIND_ROW;
    r.code_length = 5'(len);
    r.min_code = minc;
    r.max_code = maxc;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic flag(input string msg);
    $display("ERROR: result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] g, input logic [31:0] w);
    if (g !== w) flag($sformatf("%s got 0x%0h want 0x%0h", name, g, w));
  endtask

  task automatic add_row(input logic first, input logic [7:0] val, input logic typed,
                         input jhtb_result_t res);
    dir_row_t d;
    d.first = first;
    d.val = val;
    d.typed = typed;
    d.res = res;
    dir_rows.push_back(d);
  endtask

  task automatic push_byte(input logic first, input logic [7:0] b, input logic typed,
                           input jhtb_result_t tr);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= b;
    exp_typed <= typed;
    exp_fixed <= tr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items++;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_table(input shape_t shape);
    int cnt[NLEN];
    int run, total, cap, c, nsym, len, k, full;
    run = 0;
    total = 0;
    full = $urandom_range(0, 1);
    if (shape == SHAPE_NOISE) begin
      len = $urandom_range(1, 30);
      for (k = 0; k < len; k++)
        push_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    for (k = 0; k < NLEN; k++) begin
      cap = (1 << (k + 1)) - run;
      if (cap > 255) cap = 255;
      if (cap < 0) cap = 0;
      c = 0;
      case (shape)
        SHAPE_OVF: begin
          if ($urandom_range(0, 2) == 0) c = $urandom_range(0, 255);
        end
        SHAPE_BIG: begin
          if (k == 8) c = $urandom_range(200, 255);
          else if (k == 9) c = full ? 256 - cnt[8] : $urandom_range(60, 255);
          else if (k > 9 && !full && $urandom_range(0, 3) == 0) c = $urandom_range(0, cap);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) c = $urandom_range(0, (cap < 6) ? cap : 6);
          if ($urandom_range(0, 15) == 0) c = cap;
          if (total + c > 40) c = 0;
        end
      endcase
      if (shape != SHAPE_OVF && c > cap) c = cap;
      cnt[k] = c;
      run = 2 * (run + c);
      if (run > 'h1FFFF) run = 'h1FFFF;
      total += c;
    end
    nsym = (total > MAXSYM) ? MAXSYM : total;
    if (shape == SHAPE_OVF) begin
      c = $urandom_range(0, 12);
      if (nsym > c) nsym = c;
    end
    len = NLEN + nsym;
    if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(1, NLEN + nsym);
    for (k = 0; k < len; k++) begin
      if (k < NLEN) push_byte(k == 0, 8'(cnt[k]), 1'b0, '0);
      else push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold == 0) begin
      if (!rx_idle || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        rx_hold <= $urandom_range(0, 8);
      end else begin
        m_tready <= 1'b0;
        rx_hold <= pick_gap();
      end
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  // request side: predict on every accepted byte
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pred_res = build_step(s_tuser, s_tdata);
      want_q.push_back(exp_typed ? exp_fixed : pred_res);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.kind        = m_tuser;
      got_res.code_length = m_tdata[4:0];
      got_res.min_code    = m_tdata[20:5];
      got_res.max_code    = m_tdata[37:21];
      got_res.first_index = m_tdata[45:38];
      got_res.symbol      = m_tdata[53:46];
      got_res.code        = m_tdata[69:54];
      got_res.status      = m_tdata[71:70];
      got_res.last        = m_tlast;
      if (want_q.size() == 0) begin
        flag("result with no request pending");
      end else begin
        want_res = want_q.pop_front();
        cmp_field("kind", got_res.kind, want_res.kind);
        cmp_field("code_length", got_res.code_length, want_res.code_length);
        cmp_field("min_code", got_res.min_code, want_res.min_code);
        cmp_field("max_code", got_res.max_code, want_res.max_code);
        cmp_field("first_index", got_res.first_index, want_res.first_index);
        cmp_field("symbol", got_res.symbol, want_res.symbol);
        cmp_field("code", got_res.code, want_res.code);
        cmp_field("status", got_res.status, want_res.status);
        cmp_field("last", got_res.last, want_res.last);
      end
      results_seen++;
    end
  end

  initial begin
    jhtb_result_t ign;
    shape_t shape;
    int tbl, r, k;
    clear_table();
    ign = '0;
    ign.kind = KIND_IGNORED;
    ign.status = STAT_AFTER;

    // empty table straight out of reset, then a stray byte
    add_row(1'b0, 8'h00, 1'b1, row_res(1, 16'd0, '1, STAT_OK, 1'b0));
    for (k = 2; k < NLEN; k++) add_row(1'b0, 8'h00, 1'b0, '0);
    add_row(1'b0, 8'h00, 1'b1, row_res(NLEN, 16'd0, '1, STAT_OK, 1'b1));
    add_row(1'b0, 8'hA5, 1'b1, ign);
    // code space overflow on the first row, sticky on the next
    add_row(1'b1, 8'hFF, 1'b1, row_res(1, 16'd0, 17'd254, STAT_OVF, 1'b0));
    add_row(1'b0, 8'hFF, 1'b0, '0);
    add_row(1'b0, 8'h80, 1'b0, '0);
    // restart mid-table
    add_row(1'b1, 8'h02, 1'b1, row_res(1, 16'd0, 17'd1, STAT_OK, 1'b0));
    add_row(1'b1, 8'h01, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) push_byte(dir_rows[i].first, dir_rows[i].val,
                                    dir_rows[i].typed, dir_rows[i].res);

    tbl = 0;
    while (items < dir_rows.size() + N_RANDOM) begin
      tx_idle = ($urandom_range(0, 4) != 0);
      rx_idle = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (tbl == 3 || tbl == 12) shape = SHAPE_BIG;
      else if (r < 66) shape = SHAPE_PLAIN;
      else if (r < 78) shape = SHAPE_OVF;
      else if (r < 90) shape = SHAPE_NOISE;
      else if (r < 93) shape = SHAPE_BIG;
      else shape = SHAPE_PLAIN;
      send_table(shape);
      if (tbl == 8) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (want_q.size() != 0);
      end
      tbl++;
    end

    s_tvalid <= 1'b0;
    rx_idle = 1'b1;
    do @(posedge clk); while (want_q.size() != 0);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
